// ===== rtl/core/atte_pkg.sv =====
// Shared types, character codes and pen helpers for the ANSI text terminal engine.
// No dependencies; imported by atte_csi_parser and ansi_text_terminal_engine.
package atte_pkg;

  localparam int NUM_W = 14;
  localparam logic [NUM_W-1:0] NUM_MAX = 14'd9999;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_LF_F = 8'h66;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_U    = 8'h75;

  // cell word: char in [7:0], fg in [11:8], bg in [15:12]
  localparam logic [15:0] CELL_BLANK = 16'h0720;
  localparam logic [3:0]  PEN_FG_RST = 4'd7;
  localparam logic [3:0]  PEN_BG_RST = 4'd0;

  typedef enum logic [2:0] {
    PR_MORE = 3'b001,
    PR_DONE = 3'b010,
    PR_FAIL = 3'b100
  } parse_res_t;

  typedef struct packed {
    parse_res_t       res;
    logic [7:0]       fin;
    logic [1:0]       mask;
    logic [NUM_W-1:0] n1;
    logic [NUM_W-1:0] n2;
  } parse_t;

  function automatic logic [2:0] ansi_to_vga(input logic [2:0] a);
    logic [2:0] v;
    case (a)
      3'd0: v = 3'd0;
      3'd1: v = 3'd4;
      3'd2: v = 3'd2;
      3'd3: v = 3'd6;
      3'd4: v = 3'd1;
      3'd5: v = 3'd5;
      3'd6: v = 3'd3;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

  // pen is {bg, fg}
  function automatic logic [7:0] sgr_apply(input logic [7:0] pen, input logic [NUM_W-1:0] n);
    logic [7:0]       p;
    logic [NUM_W-1:0] d3;
    logic [NUM_W-1:0] d4;
    p  = pen;
    d3 = n - NUM_W'(30);
    d4 = n - NUM_W'(40);
    if (n == '0) begin
      p = {PEN_BG_RST, PEN_FG_RST};
    end else if (n == NUM_W'(1)) begin
      p[3] = 1'b1;
    end else if (n >= NUM_W'(30) && n <= NUM_W'(37)) begin
      p[2:0] = ansi_to_vga(d3[2:0]);
    end else if (n >= NUM_W'(40) && n <= NUM_W'(47)) begin
      p[7:4] = {1'b0, ansi_to_vga(d4[2:0])};
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/atte_ram.sv =====
// Single write port, single read port memory with registered read data.
// No dependencies; used for the cell store and the escape sequence buffer.
module atte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9600
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/atte_csi_parser.sv =====
// Incremental CSI parser: one byte per step, keeps form state and both numbers.
// Depends on atte_pkg.
module atte_csi_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output atte_pkg::parse_t pr
);
  import atte_pkg::*;

  typedef enum logic [4:0] {
    P_LBR   = 5'b00001,
    P_FIRST = 5'b00010,
    P_N1    = 5'b00100,
    P_SEMI  = 5'b01000,
    P_N2    = 5'b10000
  } pst_t;

  pst_t             pst, pst_next;
  logic [1:0]       mask, mask_next;
  logic [NUM_W-1:0] n1, n1_next, n2, n2_next;
  logic             dig;
  logic [7:0]       dsub;
  logic [16:0]      acc1, acc2;
  logic [NUM_W-1:0] n1s, n2s, dval;
  parse_res_t       res;

  assign dig  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign dsub = rx_byte - CH_0;
  assign dval = NUM_W'(dsub[3:0]);
  assign acc1 = (17'(n1) << 3) + (17'(n1) << 1) + 17'(dsub[3:0]);
  assign acc2 = (17'(n2) << 3) + (17'(n2) << 1) + 17'(dsub[3:0]);
  assign n1s  = (acc1 > 17'(NUM_MAX)) ? NUM_MAX : acc1[NUM_W-1:0];
  assign n2s  = (acc2 > 17'(NUM_MAX)) ? NUM_MAX : acc2[NUM_W-1:0];

  always_comb begin
    pst_next  = pst;
    mask_next = mask;
    n1_next   = n1;
    n2_next   = n2;
    res       = PR_FAIL;
    case (pst)
      P_LBR: begin
        if (rx_byte == CH_LBR) begin
          res = PR_MORE;
          pst_next = P_FIRST;
        end
      end
      P_FIRST: begin
        if (dig) begin
          res = PR_MORE;
          n1_next = dval;
          mask_next = 2'b01;
          pst_next = P_N1;
        end else if (rx_byte == CH_H || rx_byte == CH_S || rx_byte == CH_U ||
                     rx_byte == CH_J || rx_byte == CH_K || rx_byte == CH_M) begin
          res = PR_DONE;
        end
      end
      P_N1: begin
        if (dig) begin
          res = PR_MORE;
          n1_next = n1s;
        end else if (rx_byte == CH_SEMI) begin
          res = PR_MORE;
          pst_next = P_SEMI;
        end else if (rx_byte == CH_A || rx_byte == CH_B || rx_byte == CH_C ||
                     rx_byte == CH_D || rx_byte == CH_E || rx_byte == CH_F ||
                     rx_byte == CH_J || rx_byte == CH_K || rx_byte == CH_M) begin
          res = PR_DONE;
        end
      end
      P_SEMI: begin
        if (dig) begin
          res = PR_MORE;
          n2_next = dval;
          mask_next = 2'b11;
          pst_next = P_N2;
        end
      end
      P_N2: begin
        if (dig) begin
          res = PR_MORE;
          n2_next = n2s;
        end else if (rx_byte == CH_LF_F || rx_byte == CH_H || rx_byte == CH_M) begin
          res = PR_DONE;
        end
      end
      default: res = PR_FAIL;
    endcase
  end

  // final bytes are never digits, so the registered numbers are the complete ones
  assign pr.res  = res;
  assign pr.fin  = rx_byte;
  assign pr.mask = mask;
  assign pr.n1   = n1;
  assign pr.n2   = n2;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pst  <= P_LBR;
      mask <= 2'b00;
      n1   <= '0;
      n2   <= '0;
    end else if (step) begin
      pst  <= pst_next;
      mask <= mask_next;
      n1   <= n1_next;
      n2   <= n2_next;
    end
  end

endmodule

// ===== rtl/core/ansi_text_terminal_engine.sv =====
// Top level of the ANSI text terminal engine: sequencer, cursor and pen state.
// Depends on atte_pkg, atte_ram and atte_csi_parser.

// One transaction in, one result out. Erases write each erased cell in turn, and a
// newline on the last store line copies the whole store up by one line and blanks
// the new line, all through the single write port of the cell store. A flushed
// sequence replays its bytes as plain bytes, plus any scroll they cause. After reset
// the store is cleared one cell per cycle with s_axis_tready low. The input is
// refused while an item is in progress.
module ansi_text_terminal_engine #(
  parameter int COLUMNS      = 80,
  parameter int STORE_LINES  = 120,
  parameter int VISIBLE_ROWS = 25,
  parameter int SEQ_DEPTH    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_row[14:8], read_col[21:15]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // cell_char[7:0], cell_fg[11:8], cell_bg[15:12],
                                     // cursor_col[22:16], cursor_row[29:23],
                                     // view_top[36:30], cursor_shown[37],
                                     // escape_pending[38]
);
  import atte_pkg::*;

  localparam int CELLS   = COLUMNS * STORE_LINES;
  localparam int AW      = $clog2(CELLS);
  localparam int EW      = $clog2(CELLS + 1);
  localparam int SIW     = $clog2(SEQ_DEPTH);
  localparam int SLW     = $clog2(SEQ_DEPTH + 1);
  localparam int MAX_TOP = (STORE_LINES > VISIBLE_ROWS) ? STORE_LINES - VISIBLE_ROWS : 0;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b00000001,
    S_READ       = 8'b00000010,
    S_FLUSH_RD   = 8'b00000100,
    S_FLUSH_BYTE = 8'b00001000,
    S_COPY       = 8'b00010000,
    S_COPY_END   = 8'b00100000,
    S_FILL       = 8'b01000000,
    S_DONE       = 8'b10000000
  } state_t;

  state_t          state, state_next;
  logic [6:0]      cursor_column, cursor_column_next;
  logic [6:0]      cursor_line, cursor_line_next;
  logic [6:0]      window_top, window_top_next;
  logic [3:0]      pen_fg, pen_fg_next, pen_bg, pen_bg_next;
  logic            blink_on, blink_on_next;
  logic            seq_active, seq_active_next;
  logic [SLW-1:0]  seq_len, seq_len_next;
  logic [6:0]      saved_column, saved_column_next, saved_line, saved_line_next;
  logic            saved_valid, saved_valid_next;
  logic            in_flush, in_flush_next;
  logic            booting, booting_next;
  logic [SLW-1:0]  flush_idx, flush_idx_next;
  logic [EW-1:0]   ptr, ptr_next, fill_end, fill_end_next;
  logic [15:0]     fill_val, fill_val_next;
  logic            cp_v, cp_v_next;
  logic [AW-1:0]   cp_dst, cp_dst_next;
  logic            rd_ok, rd_ok_next;
  logic [15:0]     cell_q, cell_q_next;
  logic            out_load;

  // memories
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata, cell_rdata;
  logic            sq_we, sq_re;
  logic [SIW-1:0]  sq_waddr, sq_raddr;
  logic [7:0]      sq_rdata;

  // parser
  logic            ps_clear, ps_step;
  parse_t          pr;

  logic [1:0]      in_mode;
  logic [7:0]      in_byte;
  logic [6:0]      in_row, in_col;
  logic            accept;

  assign in_mode = s_axis_tuser;
  assign in_byte = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[14:8];
  assign in_col  = s_axis_tdata[21:15];
  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;

  atte_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(cell_rdata)
  );

  atte_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_seq (
    .clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(in_byte),
    .re(sq_re), .raddr(sq_raddr), .rdata(sq_rdata)
  );

  atte_csi_parser u_parser (
    .clk(clk), .rst(rst), .clear(ps_clear), .step(ps_step), .rx_byte(in_byte), .pr(pr)
  );

  // ---------------- plain byte handler ----------------
  logic [7:0]    pb_byte;
  logic [6:0]    pb_col, pb_row, pb_wt;
  logic          pb_we, pb_scroll, pb_nl;
  logic [7:0]    pb_row1;
  logic [8:0]    pb_wlim;
  logic [AW-1:0] cur_waddr;

  assign pb_byte   = (state == S_FLUSH_BYTE) ? sq_rdata : in_byte;
  assign cur_waddr = AW'(cursor_line) * AW'(COLUMNS) + AW'(cursor_column);

  always_comb begin
    pb_col    = cursor_column;
    pb_row    = cursor_line;
    pb_wt     = window_top;
    pb_we     = 1'b0;
    pb_scroll = 1'b0;
    pb_nl     = 1'b0;
    pb_row1   = 8'(cursor_line) + 8'd1;
    case (pb_byte)
      CH_NUL, CH_ESC, CH_BEL: pb_nl = 1'b0;
      CH_CR: pb_col = '0;
      CH_LF: pb_nl = 1'b1;
      CH_BS: begin
        if (cursor_column != '0) pb_col = cursor_column - 7'd1;
      end
      default: begin
        pb_we = 1'b1;
        if (8'(cursor_column) + 8'd1 >= 8'(COLUMNS)) pb_nl = 1'b1;
        else pb_col = cursor_column + 7'd1;
      end
    endcase
    pb_wlim = 9'(window_top) + 9'(VISIBLE_ROWS);
    if (pb_nl) begin
      pb_col = '0;
      if (pb_row1 >= 8'(STORE_LINES)) begin
        pb_scroll = 1'b1;
        pb_row    = 7'(STORE_LINES - 1);
      end else begin
        pb_row = pb_row1[6:0];
      end
      if (pb_row < window_top) pb_wt = pb_row;
      else if (9'(pb_row) >= pb_wlim) pb_wt = 7'(9'(pb_row) + 9'd1 - 9'(VISIBLE_ROWS));
      if (8'(pb_wt) > 8'(MAX_TOP)) pb_wt = 7'(MAX_TOP);
    end
  end

  // ---------------- command execution ----------------
  logic [6:0]       cm_col, cm_row;
  logic             cm_save, cm_fill;
  logic [7:0]       cm_pen, cm_pen1;
  logic [EW-1:0]    cm_fs, cm_fe;
  logic [NUM_W-1:0] cnt, par, rowv, colv;
  logic [14:0]      cnt15;
  logic [7:0]       vl;
  logic [6:0]       vtop_min;
  logic [EW-1:0]    rowa, cura, rowe, wta, vla, mina;

  always_comb begin
    cnt      = pr.mask[0] ? pr.n1 : NUM_W'(1);
    par      = pr.mask[0] ? pr.n1 : '0;
    cnt15    = 15'(cnt);
    rowv     = pr.mask[0] ? pr.n1 : NUM_W'(1);
    colv     = pr.mask[1] ? pr.n2 : NUM_W'(1);
    vl       = (8'(window_top) + 8'(VISIBLE_ROWS) > 8'(STORE_LINES)) ?
               8'(STORE_LINES) : 8'(window_top) + 8'(VISIBLE_ROWS);
    vtop_min = (window_top < cursor_line) ? window_top : cursor_line;
    rowa     = EW'(cursor_line) * EW'(COLUMNS);
    cura     = rowa + EW'(cursor_column);
    rowe     = rowa + EW'(COLUMNS);
    wta      = EW'(window_top) * EW'(COLUMNS);
    vla      = EW'(vl) * EW'(COLUMNS);
    mina     = EW'(vtop_min) * EW'(COLUMNS);
    cm_col   = cursor_column;
    cm_row   = cursor_line;
    cm_save  = 1'b0;
    cm_fill  = 1'b0;
    cm_fs    = cura;
    cm_fe    = rowe;
    cm_pen1  = sgr_apply({pen_bg, pen_fg}, par);
    cm_pen   = {pen_bg, pen_fg};
    case (pr.fin)
      CH_A: if (15'(cursor_line) >= cnt15) cm_row = cursor_line - cnt[6:0];
      CH_B: if (15'(cursor_line) + cnt15 < 15'(STORE_LINES)) cm_row = cursor_line + cnt[6:0];
      CH_C: if (15'(cursor_column) + cnt15 < 15'(COLUMNS)) cm_col = cursor_column + cnt[6:0];
      CH_D: if (15'(cursor_column) >= cnt15) cm_col = cursor_column - cnt[6:0];
      CH_E: begin
        if (15'(cursor_line) + cnt15 < 15'(STORE_LINES)) begin
          cm_col = '0;
          cm_row = cursor_line + cnt[6:0];
        end
      end
      CH_F: begin
        if (15'(cursor_line) >= cnt15) begin
          cm_col = '0;
          cm_row = cursor_line - cnt[6:0];
        end
      end
      CH_H, CH_LF_F: begin
        if (rowv == '0) cm_row = '0;
        else if (rowv > NUM_W'(STORE_LINES)) cm_row = 7'(STORE_LINES - 1);
        else cm_row = 7'(rowv - NUM_W'(1));
        if (colv == '0) cm_col = '0;
        else if (colv > NUM_W'(COLUMNS)) cm_col = 7'(COLUMNS - 1);
        else cm_col = 7'(colv - NUM_W'(1));
      end
      CH_S: cm_save = 1'b1;
      CH_U: begin
        if (saved_valid) begin
          cm_col = saved_column;
          cm_row = saved_line;
        end
      end
      CH_J: begin
        if (par == '0) begin
          cm_fill = 1'b1;
          cm_fs   = cura;
          cm_fe   = (vla > rowe) ? vla : rowe;
        end else if (par == NUM_W'(1)) begin
          cm_fill = 1'b1;
          cm_fs   = mina;
          cm_fe   = cura + EW'(1);
        end else if (par == NUM_W'(2)) begin
          cm_fill = 1'b1;
          cm_fs   = wta;
          cm_fe   = vla;
        end
      end
      CH_K: begin
        if (par == '0) begin
          cm_fill = 1'b1;
          cm_fs   = cura;
          cm_fe   = rowe;
        end else if (par == NUM_W'(1)) begin
          cm_fill = 1'b1;
          cm_fs   = rowa;
          cm_fe   = cura + EW'(1);
        end else if (par == NUM_W'(2)) begin
          cm_fill = 1'b1;
          cm_fs   = rowa;
          cm_fe   = rowe;
        end
      end
      CH_M: cm_pen = pr.mask[1] ? sgr_apply(cm_pen1, pr.n2) : cm_pen1;
      default: cm_save = 1'b0;
    endcase
  end

  // ---------------- sequencer ----------------
  logic [SLW-1:0] len1;
  logic [AW-1:0]  cp_src_dst;
  logic [EW-1:0]  ptr1;

  assign len1       = seq_len + SLW'(1);
  assign ptr1       = ptr + EW'(1);
  assign cp_src_dst = AW'(ptr - EW'(COLUMNS));

  always_comb begin
    state_next         = state;
    cursor_column_next = cursor_column;
    cursor_line_next   = cursor_line;
    window_top_next    = window_top;
    pen_fg_next        = pen_fg;
    pen_bg_next        = pen_bg;
    blink_on_next      = blink_on;
    seq_active_next    = seq_active;
    seq_len_next       = seq_len;
    saved_column_next  = saved_column;
    saved_line_next    = saved_line;
    saved_valid_next   = saved_valid;
    in_flush_next      = in_flush;
    booting_next       = booting;
    flush_idx_next     = flush_idx;
    ptr_next           = ptr;
    fill_end_next      = fill_end;
    fill_val_next      = fill_val;
    cp_v_next          = 1'b0;
    cp_dst_next        = cp_dst;
    rd_ok_next         = rd_ok;
    cell_q_next        = cell_q;
    out_load           = 1'b0;
    // pending copy write lands in the cycle after its read
    mem_we             = cp_v;
    mem_waddr          = cp_dst;
    mem_wdata          = cell_rdata;
    mem_re             = 1'b0;
    mem_raddr          = AW'(in_row) * AW'(COLUMNS) + AW'(in_col);
    sq_we              = 1'b0;
    sq_waddr           = seq_len[SIW-1:0];
    sq_re              = 1'b0;
    sq_raddr           = flush_idx[SIW-1:0];
    ps_clear           = 1'b0;
    ps_step            = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cell_q_next = '0;
          state_next  = S_DONE;
          case (in_mode)
            MODE_READ: begin
              mem_re     = 1'b1;
              rd_ok_next = (8'(in_row) < 8'(STORE_LINES)) && (8'(in_col) < 8'(COLUMNS));
              state_next = S_READ;
            end
            MODE_BLINK: blink_on_next = !blink_on;
            MODE_BYTE: begin
              if (!seq_active) begin
                if (in_byte == CH_ESC) begin
                  seq_active_next = 1'b1;
                  seq_len_next    = '0;
                  ps_clear        = 1'b1;
                end else begin
                  cursor_column_next = pb_col;
                  cursor_line_next   = pb_row;
                  window_top_next    = pb_wt;
                  mem_we    = pb_we;
                  mem_waddr = cur_waddr;
                  mem_wdata = {pen_bg, pen_fg, pb_byte};
                  if (pb_scroll) begin
                    ptr_next   = EW'(COLUMNS);
                    state_next = S_COPY;
                  end
                end
              end else begin
                sq_we        = 1'b1;
                seq_len_next = len1;
                if (len1 >= SLW'(SEQ_DEPTH)) begin
                  in_flush_next  = 1'b1;
                  flush_idx_next = '0;
                  state_next     = S_FLUSH_RD;
                end else begin
                  ps_step = 1'b1;
                  case (pr.res)
                    PR_DONE: begin
                      seq_active_next    = 1'b0;
                      seq_len_next       = '0;
                      cursor_column_next = cm_col;
                      cursor_line_next   = cm_row;
                      pen_fg_next        = cm_pen[3:0];
                      pen_bg_next        = cm_pen[7:4];
                      if (cm_save) begin
                        saved_column_next = cursor_column;
                        saved_line_next   = cursor_line;
                        saved_valid_next  = 1'b1;
                      end
                      if (cm_fill) begin
                        ptr_next      = cm_fs;
                        fill_end_next = cm_fe;
                        fill_val_next = {pen_bg, pen_fg, 8'h20};
                        state_next    = S_FILL;
                      end
                    end
                    PR_FAIL: begin
                      in_flush_next  = 1'b1;
                      flush_idx_next = '0;
                      state_next     = S_FLUSH_RD;
                    end
                    default: state_next = S_DONE;
                  endcase
                end
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_READ: begin
        cell_q_next = rd_ok ? cell_rdata : '0;
        state_next  = S_DONE;
      end
      S_FLUSH_RD: begin
        if (flush_idx >= seq_len) begin
          seq_active_next = 1'b0;
          seq_len_next    = '0;
          in_flush_next   = 1'b0;
          state_next      = S_DONE;
        end else begin
          sq_re      = 1'b1;
          state_next = S_FLUSH_BYTE;
        end
      end
      S_FLUSH_BYTE: begin
        cursor_column_next = pb_col;
        cursor_line_next   = pb_row;
        window_top_next    = pb_wt;
        mem_we    = pb_we;
        mem_waddr = cur_waddr;
        mem_wdata = {pen_bg, pen_fg, pb_byte};
        flush_idx_next = flush_idx + SLW'(1);
        if (pb_scroll) begin
          ptr_next   = EW'(COLUMNS);
          state_next = S_COPY;
        end else begin
          state_next = S_FLUSH_RD;
        end
      end
      S_COPY: begin
        mem_re      = 1'b1;
        mem_raddr   = ptr[AW-1:0];
        cp_v_next   = 1'b1;
        cp_dst_next = cp_src_dst;
        ptr_next    = ptr1;
        if (ptr1 >= EW'(CELLS)) state_next = S_COPY_END;
      end
      S_COPY_END: begin
        ptr_next      = EW'((STORE_LINES - 1) * COLUMNS);
        fill_end_next = EW'(CELLS);
        fill_val_next = CELL_BLANK;
        state_next    = S_FILL;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[AW-1:0];
        mem_wdata = fill_val;
        ptr_next  = ptr1;
        if (ptr1 >= fill_end) begin
          if (booting) begin
            booting_next = 1'b0;
            state_next   = S_IDLE;
          end else if (in_flush) begin
            state_next = S_FLUSH_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      booting       <= 1'b1;
      ptr           <= '0;
      fill_end      <= EW'(CELLS);
      fill_val      <= CELL_BLANK;
      cursor_column <= '0;
      cursor_line   <= '0;
      window_top    <= '0;
      pen_fg        <= PEN_FG_RST;
      pen_bg        <= PEN_BG_RST;
      blink_on      <= 1'b0;
      seq_active    <= 1'b0;
      seq_len       <= '0;
      saved_column  <= '0;
      saved_line    <= '0;
      saved_valid   <= 1'b0;
      in_flush      <= 1'b0;
      flush_idx     <= '0;
      cp_v          <= 1'b0;
      rd_ok         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      booting       <= booting_next;
      ptr           <= ptr_next;
      fill_end      <= fill_end_next;
      fill_val      <= fill_val_next;
      cursor_column <= cursor_column_next;
      cursor_line   <= cursor_line_next;
      window_top    <= window_top_next;
      pen_fg        <= pen_fg_next;
      pen_bg        <= pen_bg_next;
      blink_on      <= blink_on_next;
      seq_active    <= seq_active_next;
      seq_len       <= seq_len_next;
      saved_column  <= saved_column_next;
      saved_line    <= saved_line_next;
      saved_valid   <= saved_valid_next;
      in_flush      <= in_flush_next;
      flush_idx     <= flush_idx_next;
      cp_v          <= cp_v_next;
      rd_ok         <= rd_ok_next;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cp_dst <= cp_dst_next;
    cell_q <= cell_q_next;
    if (out_load) begin
      m_axis_tdata <= {1'b0, seq_active, blink_on, window_top, cursor_line, cursor_column,
                       cell_q};
    end
  end

`ifndef ASSERT_OFF
  a_cursor_in_store: assert property (@(posedge clk) disable iff (rst)
    (8'(cursor_column) < 8'(COLUMNS)) && (8'(cursor_line) < 8'(STORE_LINES)))
    else $error("cursor outside the cell store");

  a_seq_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (seq_len < SLW'(SEQ_DEPTH)))
    else $error("sequence buffer full while idle");

  a_copy_write: assert property (@(posedge clk) disable iff (rst)
    cp_v |-> (state == S_COPY || state == S_COPY_END))
    else $error("scroll copy write outside the copy pass");

  a_window_top: assert property (@(posedge clk) disable iff (rst)
    8'(window_top) <= 8'(MAX_TOP))
    else $error("visible window runs past the store");
`endif

endmodule
